// File: hdl/dac_pkg.sv
// shared types and constants for the decay angle cosine pipeline
// no dependencies
`default_nettype none

package dac_pkg;

    // digit stages of the two multiplier groups
    localparam int MUL_STG_B = 4;
    localparam int MUL_STG_C = 6;

    // per-item flags that ride along the root pipeline
    typedef struct packed {
        logic neg;
        logic err;
    } t_flags;

endpackage

`default_nettype wire

// File: hdl/decay_angle_cosine.sv
// decay angle cosine in the parent rest frame, fully pipelined
// throughput: one request per cycle; a stalled output freezes the whole pipe
// reset: synchronous, active low, clears only the valid bits of the pipe
// depends on dac_pkg, dac_dly, dac_mul, dac_root
`default_nettype none

module decay_angle_cosine import dac_pkg::*; #(
    parameter int MOMENTUM_BITS = 24,
    parameter int COS_FRAC_BITS = 15
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // request side
    input  wire logic                            i_valid,
    output logic                                 o_stall,
    input  wire logic signed [MOMENTUM_BITS-1:0] i_parent_px,
    input  wire logic signed [MOMENTUM_BITS-1:0] i_parent_py,
    input  wire logic signed [MOMENTUM_BITS-1:0] i_parent_pz,
    input  wire logic        [MOMENTUM_BITS-2:0] i_parent_energy,
    input  wire logic signed [MOMENTUM_BITS-1:0] i_daughter_px,
    input  wire logic signed [MOMENTUM_BITS-1:0] i_daughter_py,
    input  wire logic signed [MOMENTUM_BITS-1:0] i_daughter_pz,
    input  wire logic        [MOMENTUM_BITS-2:0] i_daughter_energy,
    // result side
    output logic                                 o_valid,
    input  wire logic                            i_stall,
    output logic signed [COS_FRAC_BITS:0]        o_cos_angle,
    output logic                                 o_not_decay_product
);

    localparam int W   = MOMENTUM_BITS;
    localparam int F   = COS_FRAC_BITS;
    localparam int SW  = 2 * W + 1;      // |p|^2, p.d, |d|^2
    localparam int NW  = 3 * W + 2;      // N = (p.d) E - |p|^2 Ed
    localparam int CW  = 4 * W + 3;      // |d|^2 |p|^2 - (p.d)^2
    localparam int GW  = 2 * W + 2;      // E^2 - |p|^2
    localparam int NNW = 2 * NW;
    localparam int CGW = CW + GW;
    localparam int MW  = CGW + 1;
    localparam int NS  = F + 2;
    localparam int L   = 1 + 1 + MUL_STG_B + 1 + MUL_STG_C + 1 + NS + 1;

    // pipe control: everything moves together unless the output is held
    logic         en;
    logic [L-1:0] r_vld;

    assign en      = !(r_vld[L-1] && i_stall);
    assign o_stall = r_vld[L-1] && i_stall;
    assign o_valid = r_vld[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[L-2:0], i_valid};
        end
    end

    // stage 1: component products
    logic signed [2*W-1:0] r_pxx, r_pyy, r_pzz;
    logic signed [2*W-1:0] r_pdx, r_pdy, r_pdz;
    logic signed [2*W-1:0] r_dxx, r_dyy, r_dzz;
    logic        [W-2:0]   r_e1, r_ed1;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pxx <= i_parent_px * i_parent_px;
            r_pyy <= i_parent_py * i_parent_py;
            r_pzz <= i_parent_pz * i_parent_pz;
            r_pdx <= i_parent_px * i_daughter_px;
            r_pdy <= i_parent_py * i_daughter_py;
            r_pdz <= i_parent_pz * i_daughter_pz;
            r_dxx <= i_daughter_px * i_daughter_px;
            r_dyy <= i_daughter_py * i_daughter_py;
            r_dzz <= i_daughter_pz * i_daughter_pz;
            r_e1  <= i_parent_energy;
            r_ed1 <= i_daughter_energy;
        end
    end

    // stage 2: the three dot products, parent-at-rest or zero-energy check
    logic signed [SW-1:0] n_p2;
    logic signed [SW-1:0] r_p2, r_dot, r_d2;
    logic signed [W-1:0]  r_e2, r_ed2;
    logic                 r_z2;

    assign n_p2 = SW'(r_pxx) + SW'(r_pyy) + SW'(r_pzz);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p2  <= n_p2;
            r_dot <= SW'(r_pdx) + SW'(r_pdy) + SW'(r_pdz);
            r_d2  <= SW'(r_dxx) + SW'(r_dyy) + SW'(r_dzz);
            r_e2  <= $signed({1'b0, r_e1});
            r_ed2 <= $signed({1'b0, r_ed1});
            r_z2  <= (n_p2 == '0) || (r_e1 == '0);
        end
    end

    // multiplier group b: the products that build N, the transverse term and E^2 - |p|^2
    logic signed [SW+W-1:0] dot_e, p2_ed;
    logic signed [2*SW-1:0] d2_p2, dot_dot;
    logic signed [2*W-1:0]  e_e;
    logic        [SW-1:0]   p2_dly;
    logic                   z_dly;

    dac_mul #(.AW(SW), .BW(W), .STG(MUL_STG_B)) u_mul_dot_e (
        .i_clk(i_clk), .i_en(en), .i_a(r_dot), .i_b(r_e2), .o_p(dot_e)
    );
    dac_mul #(.AW(SW), .BW(W), .STG(MUL_STG_B)) u_mul_p2_ed (
        .i_clk(i_clk), .i_en(en), .i_a(r_p2), .i_b(r_ed2), .o_p(p2_ed)
    );
    dac_mul #(.AW(SW), .BW(SW), .STG(MUL_STG_B)) u_mul_d2_p2 (
        .i_clk(i_clk), .i_en(en), .i_a(r_d2), .i_b(r_p2), .o_p(d2_p2)
    );
    dac_mul #(.AW(SW), .BW(SW), .STG(MUL_STG_B)) u_mul_dot_dot (
        .i_clk(i_clk), .i_en(en), .i_a(r_dot), .i_b(r_dot), .o_p(dot_dot)
    );
    dac_mul #(.AW(W), .BW(W), .STG(MUL_STG_B)) u_mul_e_e (
        .i_clk(i_clk), .i_en(en), .i_a(r_e2), .i_b(r_e2), .o_p(e_e)
    );

    dac_dly #(.W(SW), .N(MUL_STG_B)) u_dly_p2 (
        .i_clk(i_clk), .i_en(en), .i_d(r_p2), .o_d(p2_dly)
    );
    dac_dly #(.W(1), .N(MUL_STG_B)) u_dly_z (
        .i_clk(i_clk), .i_en(en), .i_d(r_z2), .o_d(z_dly)
    );

    // stage 3: N, transverse term, mass term
    logic signed [NW-1:0] r_n;
    logic signed [CW-1:0] r_c;
    logic signed [GW-1:0] r_g;
    logic                 r_z3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_n  <= NW'(dot_e) - NW'(p2_ed);
            r_c  <= CW'(d2_p2) - CW'(dot_dot);
            r_g  <= GW'(e_e) - GW'($signed(p2_dly));
            r_z3 <= z_dly;
        end
    end

    // multiplier group c: N^2 and the transverse product
    logic signed [NNW-1:0] nn;
    logic signed [CGW-1:0] cg;
    t_flags                f3, f_dly;

    assign f3.neg = r_n[NW-1];
    assign f3.err = r_z3;

    dac_mul #(.AW(NW), .BW(NW), .STG(MUL_STG_C)) u_mul_nn (
        .i_clk(i_clk), .i_en(en), .i_a(r_n), .i_b(r_n), .o_p(nn)
    );
    dac_mul #(.AW(CW), .BW(GW), .STG(MUL_STG_C)) u_mul_cg (
        .i_clk(i_clk), .i_en(en), .i_a(r_c), .i_b(r_g), .o_p(cg)
    );
    dac_dly #(.W($bits(t_flags)), .N(MUL_STG_C)) u_dly_f (
        .i_clk(i_clk), .i_en(en), .i_d(f3), .o_d(f_dly)
    );

    // stage 4: squared denominator M and its sign check
    logic signed [MW-1:0]  n_m;
    logic        [MW-1:0]  r_m;
    logic        [NNW-1:0] r_nn;
    t_flags                r_f4;

    assign n_m = MW'(nn) + MW'(cg);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_m      <= n_m;
            r_nn     <= nn;
            r_f4.neg <= f_dly.neg;
            // a zero parent or a denominator that is not positive is flagged
            r_f4.err <= f_dly.err || n_m[MW-1] || (n_m == '0);
        end
    end

    // root search: r = floor(2^(F+1) |N| / sqrt(M)), capped below 2^(F+2)
    logic [NS-1:0] root;
    t_flags        f_root;

    dac_root #(.MW(MW), .NNW(NNW), .FB(F)) u_root (
        .i_clk(i_clk), .i_en(en), .i_m(r_m), .i_nn(r_nn), .i_flags(r_f4),
        .o_root(root), .o_flags(f_root)
    );

    // output stage: round half away from zero, saturate, apply sign; errors give the largest positive code
    localparam logic [NS-1:0] ONE = NS'(1) << F;

    logic [NS:0]    rsum;
    logic [NS-1:0]  q, qs;
    logic [F:0]     n_cos;
    logic [F:0]     r_cos;
    logic           r_flag;

    assign rsum = {1'b0, root} + (NS+1)'(1);
    assign q    = rsum[NS:1];

    always_comb begin
        qs    = q;
        n_cos = '0;
        if (f_root.err) begin
            n_cos = {1'b0, {F{1'b1}}};
        end else if (f_root.neg) begin
            if (q > ONE) begin
                qs = ONE;
            end
            n_cos = (F+1)'(NS'(0) - qs);
        end else begin
            if (q > ONE - NS'(1)) begin
                qs = ONE - NS'(1);
            end
            n_cos = qs[F:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cos  <= n_cos;
            r_flag <= f_root.err;
        end
    end

    assign o_cos_angle         = $signed(r_cos);
    assign o_not_decay_product = r_flag;

endmodule

`default_nettype wire

// File: hdl/dac_dly.sv
// enabled delay line for side-band data
// no dependencies
`default_nettype none

module dac_dly #(
    parameter int W = 8,
    parameter int N = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire logic [W-1:0] i_d,
    output logic      [W-1:0] o_d
);

    logic [W-1:0] r_sr [N];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sr[0] <= i_d;
            for (int k = 1; k < N; k++) begin
                r_sr[k] <= r_sr[k-1];
            end
        end
    end

    assign o_d = r_sr[N-1];

endmodule

`default_nettype wire

// File: hdl/dac_mul.sv
// pipelined signed multiplier, one digit of b per stage
// no dependencies
`default_nettype none

module dac_mul #(
    parameter int AW  = 49,
    parameter int BW  = 24,
    parameter int STG = 4
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_en,
    input  wire logic signed [AW-1:0] i_a,
    input  wire logic signed [BW-1:0] i_b,
    output logic signed [AW+BW-1:0]   o_p
);

    localparam int PW = AW + BW;
    localparam int DW = (BW + STG - 1) / STG;
    localparam int BP = STG * DW;

    logic signed [PW-1:0] r_acc [STG];
    logic signed [AW-1:0] r_a   [STG-1];
    logic signed [BP-1:0] r_b   [STG-1];
    logic signed [BP-1:0] b_ext;

    assign b_ext = BP'(i_b);

    for (genvar k = 0; k < STG; k++) begin : g_stg
        logic signed [AW-1:0] a_in;
        logic signed [BP-1:0] b_in;
        logic signed [PW-1:0] acc_in;
        logic signed [DW:0]   dig;
        logic signed [PW-1:0] part;

        if (k == 0) begin : g_first
            assign a_in   = i_a;
            assign b_in   = b_ext;
            assign acc_in = '0;
        end else begin : g_next
            assign a_in   = r_a[k-1];
            assign b_in   = r_b[k-1];
            assign acc_in = r_acc[k-1];
        end

        // top digit carries the sign, the rest are unsigned
        if (k == STG - 1) begin : g_top
            assign dig = {b_in[BP-1], b_in[k*DW +: DW]};
        end else begin : g_low
            assign dig = {1'b0, b_in[k*DW +: DW]};
        end

        assign part = PW'(a_in) * PW'(dig);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc[k] <= acc_in + (part <<< (k * DW));
            end
        end

        if (k < STG - 1) begin : g_fwd
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_a[k] <= a_in;
                    r_b[k] <= b_in;
                end
            end
        end
    end

    assign o_p = r_acc[STG-1];

endmodule

`default_nettype wire

// File: hdl/dac_root.sv
// restoring search for the largest r with r^2 * m <= nn * 4^(fb+1)
// depends on dac_pkg; one result bit per stage, fb+2 stages
`default_nettype none

module dac_root import dac_pkg::*; #(
    parameter int MW  = 150,
    parameter int NNW = 148,
    parameter int FB  = 15
) (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire logic [MW-1:0] i_m,
    input  wire logic [NNW-1:0] i_nn,
    input  wire t_flags        i_flags,
    output logic [FB+1:0]      o_root,
    output t_flags             o_flags
);

    localparam int NS = FB + 2;
    localparam int RW = MW + 2 * FB + 5;
    localparam int AW = MW + FB + 2;

    logic [RW-1:0] r_rem  [NS];
    logic [AW-1:0] r_acc  [NS];
    logic [NS-1:0] r_root [NS];
    logic [MW-1:0] r_m    [NS];
    t_flags        r_flg  [NS];

    for (genvar j = 0; j < NS; j++) begin : g_bit
        localparam int B = NS - 1 - j;
        localparam logic [NS-1:0] BMASK = NS'(1) << B;

        logic [RW-1:0] rem_in;
        logic [AW-1:0] acc_in;
        logic [NS-1:0] root_in;
        logic [MW-1:0] m_in;
        t_flags        flg_in;
        logic [RW-1:0] delta;
        logic          take;

        if (j == 0) begin : g_first
            assign rem_in  = RW'(i_nn) << (2 * FB + 2);
            assign acc_in  = '0;
            assign root_in = '0;
            assign m_in    = i_m;
            assign flg_in  = i_flags;
        end else begin : g_next
            assign rem_in  = r_rem[j-1];
            assign acc_in  = r_acc[j-1];
            assign root_in = r_root[j-1];
            assign m_in    = r_m[j-1];
            assign flg_in  = r_flg[j-1];
        end

        // (r + 2^b)^2 m - r^2 m = 2^(b+1) r m + 4^b m
        assign delta = (RW'(acc_in) << (B + 1)) + (RW'(m_in) << (2 * B));
        assign take  = (delta <= rem_in);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= take ? (rem_in - delta) : rem_in;
                r_acc[j]  <= take ? (acc_in + (AW'(m_in) << B)) : acc_in;
                r_root[j] <= take ? (root_in | BMASK) : root_in;
                r_m[j]    <= m_in;
                r_flg[j]  <= flg_in;
            end
        end
    end

    assign o_root  = r_root[NS-1];
    assign o_flags = r_flg[NS-1];

endmodule

`default_nettype wire
